/* rtl/lpr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpr_pkg: shared constants and types for the LRU page replacement unit
// Widths of the page, stamp and total fields, the configuration register
// reset value and the per-frame update command.
// ----------------------------------------------------------------------------
package lpr_pkg;

  localparam int FRAMES_DEFAULT = 8;
  localparam int PAGE_W         = 16;
  localparam int STAMP_W        = 32;
  localparam int CFG_W          = 4;
  localparam int FRAME_OUT_W    = 3;
  localparam logic [CFG_W-1:0]   CFG_RESET = 4'd8;
  localparam logic [STAMP_W-1:0] COUNT_MAX = '1;

  // Update command sent to one frame cell during the commit cycle.
  typedef struct packed {
    logic               clear;  // end of string: drop valid bit and stamp
    logic               write;  // this frame was picked
    logic               load;   // fault: the frame takes a new page
    logic [PAGE_W-1:0]  page;
    logic [STAMP_W-1:0] stamp;
  } lpr_cmd_t;

endpackage

/* rtl/lru_page_replacement_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_page_replacement_unit: fully associative LRU page frame store
// Each input beat is one page reference; each output beat reports hit or
// fault, the frame used, the evicted page and saturating running totals.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid/in_ready) carries page and end_of_string. The
// output channel (out_valid/out_ready) carries one result beat per input
// beat, in order. The cfg channel writes frames_in_use (reset 8); write it
// only while no reference is in flight. cfg_ready is always high.
// Timing: a reference is taken in an idle cycle, then a search record walks
// the row of frame cells one cell per cycle, then a commit cycle updates the
// picked frame and loads the output register. The next reference is taken
// only after commit; the result appears the cycle after commit.
// When the receiver stalls, the block still takes the next reference and
// searches it; commit waits until the output register is free.
// Reset (rst, synchronous) empties all frames, clears stamps and totals and
// sets frames_in_use to 8. An end_of_string beat does the same to the
// frames and totals after its own result, leaving frames_in_use alone.
// ----------------------------------------------------------------------------
module lru_page_replacement_unit #(
  parameter int FRAMES = lpr_pkg::FRAMES_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [lpr_pkg::CFG_W-1:0]         cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [lpr_pkg::PAGE_W-1:0]        page,
  input  logic                              end_of_string,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              hit,
  output logic [lpr_pkg::FRAME_OUT_W-1:0]   frame_index,
  output logic                              evicted_valid,
  output logic [lpr_pkg::PAGE_W-1:0]        evicted_page,
  output logic [lpr_pkg::STAMP_W-1:0]       fault_total,
  output logic [lpr_pkg::STAMP_W-1:0]       hit_total
);

  localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int REC_W = 2*lpr_pkg::PAGE_W + lpr_pkg::STAMP_W + 3*IDX_W + 3;
  localparam logic [IDX_W-1:0] LAST_CNT = IDX_W'(FRAMES - 1);

  typedef struct packed {
    logic [lpr_pkg::PAGE_W-1:0]  page;
    logic                        found;
    logic [IDX_W-1:0]            hit_idx;
    logic                        has_empty;
    logic [IDX_W-1:0]            empty_idx;
    logic                        have_min;
    logic [lpr_pkg::STAMP_W-1:0] min_stamp;
    logic [IDX_W-1:0]            min_idx;
    logic [lpr_pkg::PAGE_W-1:0]  min_page;
  } scan_t;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_COMMIT = 3'b100
  } state_t;

  function automatic logic [lpr_pkg::STAMP_W-1:0] sat_inc(
    input logic [lpr_pkg::STAMP_W-1:0] v
  );
    return (v == lpr_pkg::COUNT_MAX) ? v : v + 1'b1;
  endfunction

  state_t                       state;
  state_t                       state_next;
  logic [IDX_W-1:0]             scan_cnt;
  logic [lpr_pkg::CFG_W-1:0]    frames_in_use;
  logic                         eos_q;
  scan_t                        scan_head;
  scan_t                        scan_head_next;
  logic [REC_W-1:0]             link [FRAMES+1];
  scan_t                        rec;
  logic [FRAMES-1:0]            active;
  lpr_pkg::lpr_cmd_t            cmd [FRAMES];
  logic [lpr_pkg::STAMP_W-1:0]  ref_counter;
  logic [lpr_pkg::STAMP_W-1:0]  fault_counter;
  logic [lpr_pkg::STAMP_W-1:0]  hit_counter;
  logic [lpr_pkg::STAMP_W-1:0]  stamp_new;
  logic [IDX_W-1:0]             pick;
  logic                         in_accept;
  logic                         commit;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign in_accept = in_valid && in_ready;
  assign commit    = (state == S_COMMIT) && (!out_valid || out_ready);
  assign link[0]   = scan_head;
  assign rec       = link[FRAMES];
  assign stamp_new = sat_inc(ref_counter);

  always_comb begin
    priority if (rec.found) begin
      pick = rec.hit_idx;
    end else if (rec.has_empty) begin
      pick = rec.empty_idx;
    end else begin
      pick = rec.min_idx;
    end
  end

  for (genvar k = 0; k < FRAMES; k++) begin : g_cell
    // Frame 0 always takes part; a count of zero acts as one.
    assign active[k] = (k == 0) || (32'(k) < 32'(frames_in_use));

    always_comb begin
      cmd[k].clear = commit && eos_q;
      cmd[k].write = commit && (pick == IDX_W'(k));
      cmd[k].load  = !rec.found;
      cmd[k].page  = rec.page;
      cmd[k].stamp = stamp_new;
    end

    lpr_cell #(
      .IDX_W (IDX_W),
      .INDEX (k)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .active   (active[k]),
      .cmd      (cmd[k]),
      .scan_in  (link[k]),
      .scan_out (link[k+1])
    );
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_accept) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_cnt == LAST_CNT) begin
          state_next = S_COMMIT;
        end
      end
      S_COMMIT: begin
        if (commit) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      scan_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == S_SCAN) begin
        scan_cnt <= scan_cnt + 1'b1;
      end else begin
        scan_cnt <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frames_in_use <= lpr_pkg::CFG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      frames_in_use <= cfg_data;
    end
  end

  // The head record enters cell 0 empty apart from the referenced page.
  always_comb begin
    scan_head_next      = '0;
    scan_head_next.page = page;
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      scan_head <= scan_head_next;
      eos_q     <= end_of_string;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ref_counter   <= '0;
      fault_counter <= '0;
      hit_counter   <= '0;
    end else if (commit) begin
      if (eos_q) begin
        ref_counter   <= '0;
        fault_counter <= '0;
        hit_counter   <= '0;
      end else begin
        ref_counter <= stamp_new;
        if (rec.found) begin
          hit_counter <= sat_inc(hit_counter);
        end else begin
          fault_counter <= sat_inc(fault_counter);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      hit           <= rec.found;
      frame_index   <= lpr_pkg::FRAME_OUT_W'(pick);
      evicted_valid <= !rec.found && !rec.has_empty;
      evicted_page  <= (!rec.found && !rec.has_empty) ? rec.min_page : '0;
      fault_total   <= rec.found ? fault_counter : sat_inc(fault_counter);
      hit_total     <= rec.found ? sat_inc(hit_counter) : hit_counter;
    end
  end

  a_accept_starts_scan: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> (state == S_SCAN) && (scan_cnt == '0))
    else $error("accepted reference did not start a scan");

  a_commit_loads_output: assert property (@(posedge clk) disable iff (rst)
    commit |=> out_valid && (state == S_IDLE))
    else $error("commit did not load the output register");

  a_commit_has_choice: assert property (@(posedge clk) disable iff (rst)
    commit |-> (rec.found || rec.has_empty || rec.have_min))
    else $error("search record reached commit with no candidate frame");

  a_totals_bounded: assert property (@(posedge clk) disable iff (rst)
    (ref_counter >= fault_counter) && (ref_counter >= hit_counter))
    else $error("a running total exceeds the reference count");

endmodule

/* rtl/lpr_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpr_cell: one page frame of the replacement chain
// Holds the frame's page, valid bit and last-use stamp, folds them into the
// search record coming from its left neighbor and registers the result for
// the next cell.
// ----------------------------------------------------------------------------
module lpr_cell #(
  parameter int IDX_W = 3,
  parameter int INDEX = 0
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     active,
  input  lpr_pkg::lpr_cmd_t        cmd,
  input  logic [2*lpr_pkg::PAGE_W+lpr_pkg::STAMP_W+3*IDX_W+2:0] scan_in,
  output logic [2*lpr_pkg::PAGE_W+lpr_pkg::STAMP_W+3*IDX_W+2:0] scan_out
);

  typedef struct packed {
    logic [lpr_pkg::PAGE_W-1:0]  page;
    logic                        found;
    logic [IDX_W-1:0]            hit_idx;
    logic                        has_empty;
    logic [IDX_W-1:0]            empty_idx;
    logic                        have_min;
    logic [lpr_pkg::STAMP_W-1:0] min_stamp;
    logic [IDX_W-1:0]            min_idx;
    logic [lpr_pkg::PAGE_W-1:0]  min_page;
  } scan_t;

  logic                        valid;
  logic [lpr_pkg::PAGE_W-1:0]  page_q;
  logic [lpr_pkg::STAMP_W-1:0] stamp;
  scan_t                       rec_in;
  scan_t                       rec_next;
  scan_t                       rec;

  assign rec_in   = scan_in;
  assign scan_out = rec;

  always_comb begin
    rec_next = rec_in;
    if (active) begin
      if (!rec_in.found && valid && (page_q == rec_in.page)) begin
        rec_next.found   = 1'b1;
        rec_next.hit_idx = IDX_W'(INDEX);
      end
      if (!rec_in.has_empty && !valid) begin
        rec_next.has_empty = 1'b1;
        rec_next.empty_idx = IDX_W'(INDEX);
      end
      // Strict less-than keeps the lowest index on equal stamps.
      if (valid && (!rec_in.have_min || (stamp < rec_in.min_stamp))) begin
        rec_next.have_min  = 1'b1;
        rec_next.min_stamp = stamp;
        rec_next.min_idx   = IDX_W'(INDEX);
        rec_next.min_page  = page_q;
      end
    end
  end

  always_ff @(posedge clk) begin
    rec <= rec_next;
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      valid <= 1'b0;
      stamp <= '0;
    end else if (cmd.write) begin
      stamp <= cmd.stamp;
      if (cmd.load) begin
        valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!cmd.clear && cmd.write && cmd.load) begin
      page_q <= cmd.page;
    end
  end

endmodule

/* dv/lru_page_replacement_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_page_replacement_unit_tb: self-checking bench for the LRU frame store
// Page references are driven through the input channel from a queue. Every
// accepted beat goes through a behavioral LRU store that works out the hit or
// fault, the frame used, the evicted page and the running totals. Every result
// beat is checked against the oldest prediction. The frame count register is
// changed between phases while the block is idle. Both channels stall at random.
// ----------------------------------------------------------------------------
module lru_page_replacement_unit_tb;

  localparam int NFRAMES = lpr_pkg::FRAMES_DEFAULT;
  localparam int RANDOM_PHASES = 6;
  localparam int REFS_PER_PHASE = 225;

  typedef logic [lpr_pkg::PAGE_W-1:0] page_val_t;
  typedef logic [lpr_pkg::CFG_W-1:0]  cfg_val_t;
  typedef logic [lpr_pkg::STAMP_W-1:0] count_val_t;

  typedef struct packed {
    page_val_t pg;
    logic      last;
  } page_ref_t;

  typedef struct packed {
    logic                            hit;
    logic [lpr_pkg::FRAME_OUT_W-1:0] frame;
    logic                            ev_valid;
    page_val_t                       ev_page;
    count_val_t                      faults;
    count_val_t                      hits;
  } ref_report_t;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  cfg_val_t                        cfg_data = '0;
  logic                            in_valid = 1'b0;
  logic                            in_ready;
  page_val_t                       page = '0;
  logic                            end_of_string = 1'b0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  logic                            hit;
  logic [lpr_pkg::FRAME_OUT_W-1:0] frame_index;
  logic                            evicted_valid;
  page_val_t                       evicted_page;
  count_val_t                      fault_total;
  count_val_t                      hit_total;

  page_ref_t   pending_refs[$];
  ref_report_t expected_reports[$];
  int          mismatches = 0;
  bit          steady = 1'b0;

  // Behavioral copy of the frame store.
  cfg_val_t                     frames_cfg = lpr_pkg::CFG_RESET;
  bit [lpr_pkg::PAGE_W-1:0]     frame_tag[NFRAMES];
  bit                           frame_used[NFRAMES];
  bit [lpr_pkg::STAMP_W-1:0]    frame_stamp[NFRAMES];
  bit [lpr_pkg::STAMP_W-1:0]    ref_count = '0;
  bit [lpr_pkg::STAMP_W-1:0]    fault_count = '0;
  bit [lpr_pkg::STAMP_W-1:0]    hit_count = '0;

  lru_page_replacement_unit uut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .page          (page),
    .end_of_string (end_of_string),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .hit           (hit),
    .frame_index   (frame_index),
    .evicted_valid (evicted_valid),
    .evicted_page  (evicted_page),
    .fault_total   (fault_total),
    .hit_total     (hit_total)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bit [lpr_pkg::STAMP_W-1:0] sat_inc(
    input bit [lpr_pkg::STAMP_W-1:0] v
  );
    return (v == lpr_pkg::COUNT_MAX) ? v : v + 1'b1;
  endfunction

  task automatic lru_lookup(input page_val_t pg, input logic last);
    int          n;
    int          pick;
    bit          found;
    bit          empty;
    ref_report_t r;
    n = (frames_cfg == 0) ? 1 : (frames_cfg > NFRAMES) ? NFRAMES : int'(frames_cfg);
    ref_count = sat_inc(ref_count);
    found = 1'b0;
    empty = 1'b0;
    pick = 0;
    r = '0;
    for (int i = 0; i < n; i++) begin
      if (!found && frame_used[i] && frame_tag[i] == pg) begin
        found = 1'b1;
        pick = i;
      end
    end
    if (found) begin
      frame_stamp[pick] = ref_count;
      hit_count = sat_inc(hit_count);
    end else begin
      for (int i = 0; i < n; i++) begin
        if (!empty && !frame_used[i]) begin
          empty = 1'b1;
          pick = i;
        end
      end
      // No empty frame: the oldest stamp loses, lowest index on a tie.
      if (!empty) begin
        pick = 0;
        for (int i = 1; i < n; i++) begin
          if (frame_stamp[i] < frame_stamp[pick]) pick = i;
        end
        r.ev_valid = 1'b1;
        r.ev_page = frame_tag[pick];
      end
      frame_tag[pick] = pg;
      frame_used[pick] = 1'b1;
      frame_stamp[pick] = ref_count;
      fault_count = sat_inc(fault_count);
    end
    r.hit = found;
    r.frame = pick[lpr_pkg::FRAME_OUT_W-1:0];
    r.faults = fault_count;
    r.hits = hit_count;
    expected_reports.push_back(r);
    // The end of a string wipes the store but leaves page tags and the register.
    if (last) begin
      for (int i = 0; i < NFRAMES; i++) begin
        frame_used[i] = 1'b0;
        frame_stamp[i] = '0;
      end
      ref_count = '0;
      fault_count = '0;
      hit_count = '0;
    end
  endtask

  // Input driver.
  always @(posedge clk) begin
    page_ref_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) lru_lookup(page, end_of_string);
      if (!in_valid || in_ready) begin
        if (pending_refs.size() != 0 && (steady || $urandom_range(0, 99) >= 13)) begin
          nxt = pending_refs.pop_front();
          in_valid <= 1'b1;
          page <= nxt.pg;
          end_of_string <= nxt.last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor.
  always @(posedge clk) begin
    ref_report_t got;
    ref_report_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got = '{hit, frame_index, evicted_valid, evicted_page, fault_total, hit_total};
        if (expected_reports.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result beat: hit=%0d frame=%0d ev=%0d/%h faults=%0d hits=%0d",
                     got.hit, got.frame, got.ev_valid, got.ev_page, got.faults, got.hits);
        end else begin
          want = expected_reports.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch: expected hit=%0d frame=%0d ev=%0d/%h faults=%0d hits=%0d",
                       want.hit, want.frame, want.ev_valid, want.ev_page, want.faults,
                       want.hits);
              $display("          actual   hit=%0d frame=%0d ev=%0d/%h faults=%0d hits=%0d",
                       got.hit, got.frame, got.ev_valid, got.ev_page, got.faults, got.hits);
            end
          end
        end
      end
      out_ready <= steady || $urandom_range(0, 99) >= 13;
    end
  end

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_refs.size() != 0 || in_valid || expected_reports.size() != 0);
  endtask

  task automatic write_frames(input cfg_val_t v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk);
    while (!cfg_ready);
    frames_cfg = v;
    cfg_valid <= 1'b0;
  endtask

  task automatic add_ref(input page_val_t pg, input logic last);
    pending_refs.push_back('{pg, last});
  endtask

  initial begin
    page_val_t pool[16];
    int        pool_size;
    int        roll;
    cfg_val_t  phase_cfg[RANDOM_PHASES];
    phase_cfg = '{4'd8, 4'd2, 4'd15, 4'd5, 4'd1, 4'd0};
    phase_cfg[RANDOM_PHASES-1] = cfg_val_t'($urandom_range(0, 15));
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Three frames: fill the empties, refresh on hits, then evict the oldest.
    write_frames(4'd3);
    add_ref(16'h0000, 1'b0);
    add_ref(16'hFFFF, 1'b0);
    add_ref(16'h1234, 1'b0);
    add_ref(16'h0000, 1'b0);
    add_ref(16'hABCD, 1'b0);
    add_ref(16'h1234, 1'b0);
    add_ref(16'h5555, 1'b0);
    wait_idle();
    // Shrinking to one frame hides frames 1 and 2 without losing them.
    write_frames(4'd1);
    add_ref(16'hABCD, 1'b0);
    wait_idle();
    // A count of zero behaves as one.
    write_frames(4'd0);
    add_ref(16'hABCD, 1'b0);
    wait_idle();
    // Count above the frame total: two frames now hold the same page and the
    // lower one must hit. Then an end of string and a reference after it.
    write_frames(4'd15);
    add_ref(16'hABCD, 1'b0);
    add_ref(16'h5555, 1'b0);
    add_ref(16'h00FF, 1'b1);
    add_ref(16'h1234, 1'b0);
    add_ref(16'h1234, 1'b1);
    add_ref(16'h8001, 1'b0);
    wait_idle();

    // Random strings drawn mostly from a small working set so that hits,
    // empty fills and evictions all happen, with some stray pages mixed in.
    pool_size = 0;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      write_frames(phase_cfg[p]);
      steady = (p == 2);
      for (int k = 0; k < REFS_PER_PHASE; k++) begin
        page_ref_t r;
        if (pool_size == 0) begin
          pool_size = $urandom_range(2, 16);
          for (int j = 0; j < pool_size; j++) pool[j] = page_val_t'($urandom_range(0, 65535));
        end
        roll = $urandom_range(0, 99);
        r.pg = (roll < 88) ? pool[$urandom_range(0, pool_size - 1)]
                           : page_val_t'($urandom_range(0, 65535));
        r.last = ($urandom_range(0, 39) == 0);
        if (r.last) pool_size = 0;
        pending_refs.push_back(r);
      end
      wait_idle();
    end
    steady = 1'b0;

    repeat (40) @(posedge clk);
    if (mismatches == 0)
      $display("lru_page_replacement_unit_tb: clean");
    else
      $display("lru_page_replacement_unit_tb: errors");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("lru_page_replacement_unit_tb: errors");
    $finish;
  end

endmodule
